### rtl/svag_pkg.sv
// shared widths, register codes and handshake structs for the strided view address generator
// no dependencies; compiled first
package svag_pkg;

    localparam int ADDR_W             = 16;
    localparam int IDX_PORT_W         = 16;
    localparam int EXT_W              = 16;
    localparam int STRIDE_W           = 16;
    localparam int LANE_COUNT         = 4;
    localparam int CFG_W              = 64;
    localparam int CFG_IDX_W          = 2;
    localparam int DIM_COUNT_W        = 3;
    localparam int DIV_BITS_PER_STAGE = 4;
    localparam int PROD_W             = EXT_W + 1 + STRIDE_W;

    localparam int MAX_DIMS_DEF       = 4;
    localparam int INDEX_BITS_DEF     = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIM_COUNT   = 2'd0,
        CFG_DIM_EXTENTS = 2'd1,
        CFG_DIM_STRIDES = 2'd2,
        CFG_BASE_OFFSET = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic valid;
        logic idx_err;
    } svag_ctl_t;

    typedef struct packed {
        logic [ADDR_W-1:0] source_address;
        logic              index_error;
        logic              address_error;
    } svag_result_t;

endpackage

### rtl/svag_in_if.sv
// index channel: valid, ready and the linear index of one item
// depends on svag_pkg
interface svag_in_if
    import svag_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [IDX_PORT_W-1:0] linear_index;

    modport source (output valid, output linear_index, input ready);
    modport sink (input valid, input linear_index, output ready);
endinterface

### rtl/svag_out_if.sv
// address channel: valid, ready and the result fields of one item
// depends on svag_pkg
interface svag_out_if
    import svag_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] source_address;
    logic              index_error;
    logic              address_error;

    modport source (output valid, output source_address, output index_error,
                    output address_error, input ready);
    modport sink (input valid, input source_address, input index_error,
                  input address_error, output ready);
endinterface

### rtl/strided_view_address_generator.sv
// Strided view address generator: one linear index in, one source address out, one item per
// cycle while the skid entry is free. The index runs through one lane per dimension, innermost
// first; each lane divides by its extent four quotient bits per stage, then multiplies the
// remainder by the stride and adds. Each lane registers its divider stages, then the product,
// then the sum; a full pipeline holds one item in flight per stage. An output register plus
// one skid entry keep input ready high while a single result waits. index_error is set when
// the index is not below the product of the active extents (found as a nonzero final quotient
// or a zero active extent); address_error, only without index_error, when base plus the
// stride sum leaves 0..65535. Either error forces the address to zero. Configure only while idle.
// depends on svag_pkg, svag_in_if, svag_out_if, svag_lane, svag_out_buf
module strided_view_address_generator
    import svag_pkg::*;
#(
    parameter int MAX_DIMS   = MAX_DIMS_DEF,
    parameter int INDEX_BITS = INDEX_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    svag_in_if.sink              req,
    svag_out_if.source           rsp
);

    localparam int IDX_W = (INDEX_BITS < IDX_PORT_W) ? INDEX_BITS : IDX_PORT_W;
    localparam int ACC_W = PROD_W + $clog2(MAX_DIMS) + 2;
    localparam logic [3:0] MAX_DIMS_C = 4'(MAX_DIMS);

    logic [DIM_COUNT_W-1:0]  dim_count_reg;
    logic [CFG_W-1:0]        dim_extents_reg;
    logic [CFG_W-1:0]        dim_strides_reg;
    logic [ADDR_W-1:0]       base_offset_reg;

    logic [3:0]              n_eff;
    logic [MAX_DIMS-1:0]     zero_lane;
    logic                    zero_ext;
    logic [EXT_W-1:0]        lane_extent [MAX_DIMS];
    logic signed [STRIDE_W-1:0] lane_stride [MAX_DIMS];

    svag_ctl_t               ctl_chain [MAX_DIMS+1];
    logic [IDX_W-1:0]        rest_chain [MAX_DIMS+1];
    logic signed [ACC_W-1:0] acc_chain [MAX_DIMS+1];

    logic                    adv;
    logic                    idx_err;
    logic                    addr_err;
    svag_result_t            result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_count_reg   <= DIM_COUNT_W'(1);
            dim_extents_reg <= '0;
            dim_strides_reg <= '0;
            base_offset_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_DIM_COUNT:   dim_count_reg   <= cfg_wdata[DIM_COUNT_W-1:0];
                CFG_DIM_EXTENTS: dim_extents_reg <= cfg_wdata;
                CFG_DIM_STRIDES: dim_strides_reg <= cfg_wdata;
                CFG_BASE_OFFSET: base_offset_reg <= cfg_wdata[ADDR_W-1:0];
                default:         dim_count_reg   <= dim_count_reg;
            endcase
        end
    end

    always_comb
    begin
        if (dim_count_reg == '0)
        begin
            n_eff = 4'd1;
        end
        else if ({1'b0, dim_count_reg} > MAX_DIMS_C)
        begin
            n_eff = MAX_DIMS_C;
        end
        else
        begin
            n_eff = {1'b0, dim_count_reg};
        end
    end

    for (genvar l = 0; l < MAX_DIMS; l++)
    begin : g_cfg_lane
        if (l < LANE_COUNT)
        begin : g_packed
            logic             active;
            logic [EXT_W-1:0] raw_ext;
            assign active  = 4'(l) < n_eff;
            assign raw_ext = dim_extents_reg[EXT_W*l +: EXT_W];
            assign zero_lane[l]   = active && (raw_ext == '0);
            assign lane_extent[l] = (!active || raw_ext == '0) ? EXT_W'(1) : raw_ext;
            assign lane_stride[l] = active ? $signed(dim_strides_reg[STRIDE_W*l +: STRIDE_W])
                                           : '0;
        end
        else
        begin : g_inert
            assign zero_lane[l]   = 1'b0;
            assign lane_extent[l] = EXT_W'(1);
            assign lane_stride[l] = '0;
        end
    end

    assign zero_ext = |zero_lane;

    assign req.ready          = adv;
    assign ctl_chain[0].valid   = req.valid;
    assign ctl_chain[0].idx_err = zero_ext;
    assign rest_chain[0]      = req.linear_index[IDX_W-1:0];
    assign acc_chain[0]       = {{(ACC_W-ADDR_W){1'b0}}, base_offset_reg};

    // chain position p handles lane MAX_DIMS-1-p, innermost first
    for (genvar p = 0; p < MAX_DIMS; p++)
    begin : g_lane
        svag_lane #(
            .IDX_W (IDX_W),
            .ACC_W (ACC_W)
        ) u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .ctl_in   (ctl_chain[p]),
            .rest_in  (rest_chain[p]),
            .acc_in   (acc_chain[p]),
            .extent   (lane_extent[MAX_DIMS-1-p]),
            .stride   (lane_stride[MAX_DIMS-1-p]),
            .ctl_out  (ctl_chain[p+1]),
            .rest_out (rest_chain[p+1]),
            .acc_out  (acc_chain[p+1])
        );
    end

    assign idx_err  = ctl_chain[MAX_DIMS].idx_err || (rest_chain[MAX_DIMS] != '0);
    assign addr_err = !idx_err && (acc_chain[MAX_DIMS][ACC_W-1:ADDR_W] != '0);

    assign result.index_error    = idx_err;
    assign result.address_error  = addr_err;
    assign result.source_address = (idx_err || addr_err) ? '0
                                                         : acc_chain[MAX_DIMS][ADDR_W-1:0];

    svag_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (ctl_chain[MAX_DIMS].valid),
        .push_data  (result),
        .room       (adv),
        .rsp        (rsp)
    );

`ifndef ASSERT_OFF
    a_err_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.index_error && rsp.address_error))
        else $error("index and address error both set");

    a_err_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.index_error || rsp.address_error)) |-> (rsp.source_address == '0))
        else $error("error item carries a nonzero address");

    a_zero_extent: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && zero_ext && !cfg_we) |-> rsp.index_error)
        else $error("zero active extent without index error");

    a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(req.ready) |-> $past(rsp.valid && !rsp.ready))
        else $error("input stalled without a held result");
`endif

endmodule

### rtl/svag_div_stage.sv
// one pipeline stage of the restoring divider: NBITS quotient bits, registered when adv is high
// depends on svag_pkg
module svag_div_stage
    import svag_pkg::*;
#(
    parameter int IDX_W = INDEX_BITS_DEF,
    parameter int NBITS = DIV_BITS_PER_STAGE,
    parameter int ACC_W = PROD_W + 4
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  svag_ctl_t               ctl_in,
    input  logic [IDX_W-1:0]        work_in,
    input  logic [EXT_W-1:0]        rem_in,
    input  logic signed [ACC_W-1:0] acc_in,
    input  logic [EXT_W-1:0]        extent,
    output svag_ctl_t               ctl_out,
    output logic [IDX_W-1:0]        work_out,
    output logic [EXT_W-1:0]        rem_out,
    output logic signed [ACC_W-1:0] acc_out
);

    svag_ctl_t               ctl_reg;
    logic [IDX_W-1:0]        work_reg;
    logic [IDX_W-1:0]        work_next;
    logic [EXT_W-1:0]        rem_reg;
    logic [EXT_W-1:0]        rem_next;
    logic signed [ACC_W-1:0] acc_reg;
    logic [EXT_W:0]          trial;

    // shift dividend bits into the partial remainder, quotient bits into the low end
    always_comb
    begin
        work_next = work_in;
        rem_next  = rem_in;
        trial     = '0;
        for (int i = 0; i < NBITS; i++)
        begin
            trial = {rem_next, work_next[IDX_W-1]};
            if (trial >= {1'b0, extent})
            begin
                trial     = trial - {1'b0, extent};
                work_next = {work_next[IDX_W-2:0], 1'b1};
            end
            else
            begin
                work_next = {work_next[IDX_W-2:0], 1'b0};
            end
            rem_next = trial[EXT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (adv)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
            acc_reg  <= acc_in;
        end
    end

    assign ctl_out  = ctl_reg;
    assign work_out = work_reg;
    assign rem_out  = rem_reg;
    assign acc_out  = acc_reg;

endmodule

### rtl/svag_lane.sv
// one dimension: divider stages, coordinate times stride, accumulate
// depends on svag_pkg and svag_div_stage
module svag_lane
    import svag_pkg::*;
#(
    parameter int IDX_W = INDEX_BITS_DEF,
    parameter int ACC_W = PROD_W + 4
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       adv,
    input  svag_ctl_t                  ctl_in,
    input  logic [IDX_W-1:0]           rest_in,
    input  logic signed [ACC_W-1:0]    acc_in,
    input  logic [EXT_W-1:0]           extent,
    input  logic signed [STRIDE_W-1:0] stride,
    output svag_ctl_t                  ctl_out,
    output logic [IDX_W-1:0]           rest_out,
    output logic signed [ACC_W-1:0]    acc_out
);

    localparam int STEP       = DIV_BITS_PER_STAGE;
    localparam int DIV_STAGES = (IDX_W + STEP - 1) / STEP;

    svag_ctl_t               ctl_w [DIV_STAGES+1];
    logic [IDX_W-1:0]        work_w [DIV_STAGES+1];
    logic [EXT_W-1:0]        rem_w [DIV_STAGES+1];
    logic signed [ACC_W-1:0] acc_w [DIV_STAGES+1];

    svag_ctl_t                mul_ctl_reg;
    logic [IDX_W-1:0]         mul_quot_reg;
    logic signed [PROD_W-1:0] mul_prod_reg;
    logic signed [PROD_W-1:0] mul_prod_next;
    logic signed [ACC_W-1:0]  mul_acc_reg;

    svag_ctl_t                add_ctl_reg;
    logic [IDX_W-1:0]         add_quot_reg;
    logic signed [ACC_W-1:0]  add_acc_reg;
    logic signed [ACC_W-1:0]  add_acc_next;

    assign ctl_w[0]  = ctl_in;
    assign work_w[0] = rest_in;
    assign rem_w[0]  = '0;
    assign acc_w[0]  = acc_in;

    for (genvar j = 0; j < DIV_STAGES; j++)
    begin : g_div
        localparam int NB = (j == DIV_STAGES - 1) ? (IDX_W - j * STEP) : STEP;
        svag_div_stage #(
            .IDX_W (IDX_W),
            .NBITS (NB),
            .ACC_W (ACC_W)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .ctl_in   (ctl_w[j]),
            .work_in  (work_w[j]),
            .rem_in   (rem_w[j]),
            .acc_in   (acc_w[j]),
            .extent   (extent),
            .ctl_out  (ctl_w[j+1]),
            .work_out (work_w[j+1]),
            .rem_out  (rem_w[j+1]),
            .acc_out  (acc_w[j+1])
        );
    end

    // remainder is the coordinate of this dimension
    assign mul_prod_next = $signed({1'b0, rem_w[DIV_STAGES]}) * stride;
    assign add_acc_next  = mul_acc_reg
                         + {{(ACC_W-PROD_W){mul_prod_reg[PROD_W-1]}}, mul_prod_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_ctl_reg <= '0;
            add_ctl_reg <= '0;
        end
        else if (adv)
        begin
            mul_ctl_reg <= ctl_w[DIV_STAGES];
            add_ctl_reg <= mul_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mul_quot_reg <= work_w[DIV_STAGES];
            mul_prod_reg <= mul_prod_next;
            mul_acc_reg  <= acc_w[DIV_STAGES];
            add_quot_reg <= mul_quot_reg;
            add_acc_reg  <= add_acc_next;
        end
    end

    assign ctl_out  = add_ctl_reg;
    assign rest_out = add_quot_reg;
    assign acc_out  = add_acc_reg;

endmodule

### rtl/svag_out_buf.sv
// output register with a skid entry; the pipeline advances while the skid entry is free
// depends on svag_pkg and svag_out_if
module svag_out_buf
    import svag_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    input  svag_result_t push_data,
    output logic         room,
    svag_out_if.source   rsp
);

    logic         out_valid_reg;
    svag_result_t out_data_reg;
    logic         skid_valid_reg;
    svag_result_t skid_data_reg;
    logic         push;
    logic         pop;

    assign room = !skid_valid_reg;
    assign push = push_valid && !skid_valid_reg;
    assign pop  = out_valid_reg && rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || pop)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        end
        else if (push)
        begin
            skid_data_reg <= push_data;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.source_address = out_data_reg.source_address;
    assign rsp.index_error    = out_data_reg.index_error;
    assign rsp.address_error  = out_data_reg.address_error;

endmodule
